@@ rtl/pscu_pkg.sv @@
// shared types, constants and helpers of the pressure sensor compensation unit
package pscu_pkg;

	// input word: one pressure and one temperature conversion
	typedef struct packed {
		logic [23:0] raw_pressure;
		logic [23:0] raw_temperature;
	} in_word_t;

	// output word: compensated temperature and pressure
	typedef struct packed {
		logic signed [31:0] temperature_centi;
		logic signed [31:0] pressure_value;
	} out_word_t;

	// calibration and model select as held by the register file
	typedef struct packed {
		logic        model_select;
		logic [15:0] sens_coeff;
		logic [15:0] offset_coeff;
		logic [15:0] sens_temp_coeff;
		logic [15:0] offset_temp_coeff;
		logic [15:0] ref_temp_coeff;
		logic [15:0] temp_sens_coeff;
	} cfg_t;

	// first-order results leaving the front stages
	typedef struct packed {
		logic               valid;
		logic [23:0]        d1;
		logic signed [39:0] sens;
		logic signed [41:0] off;
		logic signed [19:0] temp;
		logic [17:0]        ti_low;
		logic [17:0]        ti_high;
	} front_t;

	// second-order corrected values leaving the correction stages
	typedef struct packed {
		logic               valid;
		logic [23:0]        d1;
		logic signed [39:0] sens;
		logic signed [41:0] off;
		logic signed [20:0] temp;
	} corr_t;

	// register indexes on the configuration port
	localparam logic [2:0] REG_MODEL     = 3'd0;
	localparam logic [2:0] REG_SENS      = 3'd1;
	localparam logic [2:0] REG_OFFSET    = 3'd2;
	localparam logic [2:0] REG_SENS_TEMP = 3'd3;
	localparam logic [2:0] REG_OFF_TEMP  = 3'd4;
	localparam logic [2:0] REG_REF_TEMP  = 3'd5;
	localparam logic [2:0] REG_TEMP_SENS = 3'd6;

	// band limits on the first-order temperature
	localparam logic signed [19:0] TEMP_REF      = 20'sd2000;
	localparam logic signed [19:0] TEMP_VLOW_LIM = -20'sd1600;
	localparam logic signed [19:0] TEMP_VLOW_OFS = 20'sd1500;

	// signed divide by 2**k, truncating toward zero
	function automatic logic signed [63:0] sdiv_pow2(input logic signed [63:0] x,
		input logic [5:0] k);
		logic signed [63:0] bias;
		bias = x[63] ? ((64'sd1 <<< k) - 64'sd1) : 64'sd0;
		return (x + bias) >>> k;
	endfunction

endpackage

@@ rtl/pscu_front.sv @@
// front stages: temperature difference, products and first-order terms
module pscu_front import pscu_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      take,
	input  in_word_t  sample,
	input  cfg_t      cfg,
	output front_t    front
);

	logic               valid_s1, valid_s2, valid_s3;
	logic [23:0]        d1_s1, d1_s2, d1_s3;
	logic signed [24:0] dt_s1;
	logic signed [41:0] c3dt_s2, c4dt_s2, c6dt_s2;
	logic signed [49:0] dtsq_s2;
	logic signed [39:0] sens_s3;
	logic signed [41:0] off_s3;
	logic signed [19:0] temp_s3;
	logic [17:0]        ti_low_s3, ti_high_s3;

	logic signed [63:0] c3q, c4q, c6q;
	logic [39:0]        sens_base;
	logic [41:0]        off_base;
	logic [48:0]        dtsq_u;
	logic [52:0]        dtsq_x11;
	logic [50:0]        dtsq_x3;

	// valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= take;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	// stage 1: difference to reference temperature
	always_ff @(posedge clk) begin
		d1_s1 <= sample.raw_pressure;
		dt_s1 <= $signed({1'b0, sample.raw_temperature})
			- $signed({1'b0, cfg.ref_temp_coeff, 8'd0});
	end

	// stage 2: coefficient products and square of the difference
	always_ff @(posedge clk) begin
		d1_s2   <= d1_s1;
		c3dt_s2 <= 42'($signed({1'b0, cfg.sens_temp_coeff})) * 42'(dt_s1);
		c4dt_s2 <= 42'($signed({1'b0, cfg.offset_temp_coeff})) * 42'(dt_s1);
		c6dt_s2 <= 42'($signed({1'b0, cfg.temp_sens_coeff})) * 42'(dt_s1);
		dtsq_s2 <= 50'(dt_s1) * 50'(dt_s1);
	end

	// first-order sensitivity, offset and temperature
	always_comb begin
		c3q = cfg.model_select ? sdiv_pow2(64'(c3dt_s2), 6'd7) : sdiv_pow2(64'(c3dt_s2), 6'd8);
		c4q = cfg.model_select ? sdiv_pow2(64'(c4dt_s2), 6'd6) : sdiv_pow2(64'(c4dt_s2), 6'd7);
		c6q = sdiv_pow2(64'(c6dt_s2), 6'd23);
		sens_base = cfg.model_select ? {8'd0, cfg.sens_coeff, 16'd0}
			: {9'd0, cfg.sens_coeff, 15'd0};
		off_base  = cfg.model_select ? {9'd0, cfg.offset_coeff, 17'd0}
			: {10'd0, cfg.offset_coeff, 16'd0};
		dtsq_u   = dtsq_s2[48:0];
		dtsq_x11 = 53'(dtsq_u) * 53'd11;
		dtsq_x3  = 51'(dtsq_u) * 51'd3;
	end

	// stage 3: first-order terms and temperature correction candidates
	always_ff @(posedge clk) begin
		d1_s3      <= d1_s2;
		sens_s3    <= $signed(sens_base) + $signed(c3q[39:0]);
		off_s3     <= $signed(off_base) + $signed(c4q[41:0]);
		temp_s3    <= TEMP_REF + $signed(c6q[19:0]);
		ti_low_s3  <= cfg.model_select ? dtsq_x11[52:35] : dtsq_x3[50:33];
		ti_high_s3 <= {5'd0, dtsq_u[48:36]};
	end

	assign front.valid   = valid_s3;
	assign front.d1      = d1_s3;
	assign front.sens    = sens_s3;
	assign front.off     = off_s3;
	assign front.temp    = temp_s3;
	assign front.ti_low  = ti_low_s3;
	assign front.ti_high = ti_high_s3;

endmodule

@@ rtl/pscu_corr.sv @@
// second-order stages: band selection, squared terms and corrections
module pscu_corr import pscu_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   model_select,
	input  front_t front,
	output corr_t  corr
);

	logic               valid_s4, valid_s5;
	logic [23:0]        d1_s4, d1_s5;
	logic signed [39:0] sens_s4, sens_s5;
	logic signed [41:0] off_s4, off_s5;
	logic signed [19:0] temp_s4;
	logic signed [20:0] temp_s5;
	logic [17:0]        ti_s4;
	logic [35:0]        sq_s4, vsq_s4;
	logic               low_s4, vlow_s4;

	logic signed [19:0] dtemp, vtemp;
	logic signed [39:0] sq_full, vsq_full;
	logic               low;
	logic [41:0]        sq42, vsq42, offi, sensi;

	// valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			valid_s4 <= front.valid;
			valid_s5 <= valid_s4;
		end
	end

	// squares of the temperature offsets
	always_comb begin
		dtemp    = front.temp - TEMP_REF;
		vtemp    = front.temp + TEMP_VLOW_OFS;
		sq_full  = 40'(dtemp) * 40'(dtemp);
		vsq_full = 40'(vtemp) * 40'(vtemp);
		low      = front.temp < TEMP_REF;
	end

	// stage 4: squares, band flags and temperature correction
	always_ff @(posedge clk) begin
		d1_s4   <= front.d1;
		sens_s4 <= front.sens;
		off_s4  <= front.off;
		temp_s4 <= front.temp;
		sq_s4   <= sq_full[35:0];
		vsq_s4  <= vsq_full[35:0];
		low_s4  <= low;
		vlow_s4 <= front.temp <= TEMP_VLOW_LIM;
		if (low)
			ti_s4 <= front.ti_low;
		else if (model_select)
			ti_s4 <= 18'd0;
		else
			ti_s4 <= front.ti_high;
	end

	// offset and sensitivity corrections per model and band
	always_comb begin
		sq42  = 42'(sq_s4);
		vsq42 = 42'(vsq_s4);
		offi  = 42'd0;
		sensi = 42'd0;
		if (model_select) begin
			if (low_s4) begin
				offi  = (sq42 * 42'd31) >> 3;
				sensi = (sq42 * 42'd63) >> 5;
			end
		end else if (low_s4) begin
			offi  = ((sq42 * 42'd3) >> 1) + (vlow_s4 ? vsq42 * 42'd7 : 42'd0);
			sensi = ((sq42 * 42'd5) >> 3) + (vlow_s4 ? (vsq42 << 2) : 42'd0);
		end else begin
			offi  = sq42 >> 4;
		end
	end

	// stage 5: apply second-order corrections
	always_ff @(posedge clk) begin
		d1_s5   <= d1_s4;
		sens_s5 <= sens_s4 - $signed(sensi[39:0]);
		off_s5  <= off_s4 - $signed(offi);
		temp_s5 <= $signed({temp_s4[19], temp_s4}) - $signed({3'd0, ti_s4});
	end

	assign corr.valid = valid_s5;
	assign corr.d1    = d1_s5;
	assign corr.sens  = sens_s5;
	assign corr.off   = off_s5;
	assign corr.temp  = temp_s5;

endmodule

@@ rtl/pscu_pres.sv @@
// pressure stages: split product, scaling and output register
module pscu_pres import pscu_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      model_select,
	input  corr_t     corr,
	output logic      done,
	output out_word_t result
);

	logic               valid_s6, valid_s7, valid_s8, valid_s9;
	logic [43:0]        plo_s6;
	logic signed [44:0] phi_s6;
	logic signed [41:0] off_s6, off_s7;
	logic signed [20:0] temp_s6, temp_s7, temp_s8;
	logic signed [63:0] prod_s7;
	logic signed [43:0] diff_s8;
	out_word_t          result_s9;

	logic signed [63:0] prod_q, pval;

	// valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s6 <= 1'b0;
			valid_s7 <= 1'b0;
			valid_s8 <= 1'b0;
			valid_s9 <= 1'b0;
		end else begin
			valid_s6 <= corr.valid;
			valid_s7 <= valid_s6;
			valid_s8 <= valid_s7;
			valid_s9 <= valid_s8;
		end
	end

	// stage 6: raw pressure times low and high halves of sensitivity
	always_ff @(posedge clk) begin
		plo_s6  <= 44'(corr.d1) * 44'(corr.sens[19:0]);
		phi_s6  <= 45'($signed({1'b0, corr.d1})) * 45'($signed(corr.sens[39:20]));
		off_s6  <= corr.off;
		temp_s6 <= corr.temp;
	end

	// stage 7: join partial products
	always_ff @(posedge clk) begin
		prod_s7 <= (64'(phi_s6) <<< 20) + $signed({20'd0, plo_s6});
		off_s7  <= off_s6;
		temp_s7 <= temp_s6;
	end

	// stage 8: scale product and remove offset
	always_comb prod_q = sdiv_pow2(prod_s7, 6'd21);

	always_ff @(posedge clk) begin
		diff_s8 <= $signed(prod_q[43:0]) - 44'(off_s7);
		temp_s8 <= temp_s7;
	end

	// stage 9: final scaling into the output word
	always_comb pval = model_select ? sdiv_pow2(64'(diff_s8), 6'd15)
		: sdiv_pow2(64'(diff_s8), 6'd13);

	always_ff @(posedge clk) begin
		result_s9.temperature_centi <= 32'(temp_s8);
		result_s9.pressure_value    <= pval[31:0];
	end

	assign done   = valid_s9;
	assign result = result_s9;

endmodule

@@ rtl/pressure_sensor_compensation_unit.sv @@
// top level of the pressure sensor compensation unit: register file and pipeline
//
// channel   direction  handshake                  payload
// sample    in         start high, busy low       in_word_t  (raw_pressure, raw_temperature)
// result    out        done, one cycle, no stall  out_word_t (temperature_centi, pressure_value)
// config    in/out     apb write on access cycle  pwdata / prdata, 32 bits
//
// nine register stages, s1 to s9; an accepted word passes through them in order
// and shows on result with done from the last of them. a new word may enter every cycle,
// so busy stays low.
// the long product of raw pressure and sensitivity is cut into two partial
// products, which sets the stage count together with the two squaring stages.
// reset clears the valid bits and the calibration registers; the result side
// cannot stall, so every accepted word leaves in turn.
module pressure_sensor_compensation_unit import pscu_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  in_word_t    sample,
	output logic        done,
	output out_word_t   result,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	cfg_t       cfg_q;
	logic       wr_en;
	logic [2:0] reg_idx;
	front_t     front;
	corr_t      corr;

	assign pready  = 1'b1;
	assign busy    = 1'b0;
	assign reg_idx = paddr[4:2];
	assign wr_en   = psel && penable && pwrite && pready;

	// calibration register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_MODEL:     cfg_q.model_select      <= pwdata[0];
				REG_SENS:      cfg_q.sens_coeff        <= pwdata[15:0];
				REG_OFFSET:    cfg_q.offset_coeff      <= pwdata[15:0];
				REG_SENS_TEMP: cfg_q.sens_temp_coeff   <= pwdata[15:0];
				REG_OFF_TEMP:  cfg_q.offset_temp_coeff <= pwdata[15:0];
				REG_REF_TEMP:  cfg_q.ref_temp_coeff    <= pwdata[15:0];
				REG_TEMP_SENS: cfg_q.temp_sens_coeff   <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	// register readback
	always_comb begin
		unique case (reg_idx)
			REG_MODEL:     prdata = {31'd0, cfg_q.model_select};
			REG_SENS:      prdata = {16'd0, cfg_q.sens_coeff};
			REG_OFFSET:    prdata = {16'd0, cfg_q.offset_coeff};
			REG_SENS_TEMP: prdata = {16'd0, cfg_q.sens_temp_coeff};
			REG_OFF_TEMP:  prdata = {16'd0, cfg_q.offset_temp_coeff};
			REG_REF_TEMP:  prdata = {16'd0, cfg_q.ref_temp_coeff};
			REG_TEMP_SENS: prdata = {16'd0, cfg_q.temp_sens_coeff};
			default:       prdata = 32'd0;
		endcase
	end

	// compensation pipeline
	pscu_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.take   (start && !busy),
		.sample (sample),
		.cfg    (cfg_q),
		.front  (front)
	);

	pscu_corr u_corr (
		.clk          (clk),
		.arst_n       (arst_n),
		.model_select (cfg_q.model_select),
		.front        (front),
		.corr         (corr)
	);

	pscu_pres u_pres (
		.clk          (clk),
		.arst_n       (arst_n),
		.model_select (cfg_q.model_select),
		.corr         (corr),
		.done         (done),
		.result       (result)
	);

endmodule

@@ rtl/pscu_checker.sv @@
// port-level checks of the pressure sensor compensation unit and their binding
module pscu_checker import pscu_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        done,
	input logic        psel,
	input logic        penable,
	input logic        pwrite,
	input logic [4:0]  paddr,
	input logic [31:0] pwdata,
	input logic [31:0] prdata
);

	// every accepted word leaves after the pipeline depth
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##9 done)
		else $error("accepted word did not come out after nine cycles");

	// no word comes out that was not accepted
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, 9))
		else $error("result strobe without an accepted word");

	// a sensitivity write reads back masked to sixteen bits
	a_readback: assert property (@(posedge clk) disable iff (!arst_n)
		(psel && penable && pwrite && paddr[4:2] == REG_SENS) ##2
		(psel && penable && !pwrite && paddr[4:2] == REG_SENS)
		|-> prdata == {16'd0, $past(pwdata[15:0], 2)})
		else $error("sensitivity register readback mismatch");

endmodule

bind pressure_sensor_compensation_unit pscu_checker u_pscu_checker (.*);

@@ test/tb_top.sv @@
// testbench for the pressure sensor compensation unit: directed table, random phases, predictor
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import pscu_pkg::*;

	// index with no register behind it
	localparam logic [2:0] REG_UNMAPPED = 3'd7;

	localparam logic [23:0] RAW_MAX     = 24'hFFFFFF;
	localparam int          PHASES      = 12;
	localparam int          PHASE_WORDS = 160;
	localparam int unsigned CYCLE_LIMIT = 400000;

	logic        clk;
	logic        arst_n  = 1'b0;
	logic        start   = 1'b0;
	logic        busy;
	in_word_t    sample  = '0;
	logic        done;
	out_word_t   result;
	logic        psel    = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite  = 1'b0;
	logic [4:0]  paddr   = '0;
	logic [31:0] pwdata  = '0;
	logic [31:0] prdata;
	logic        pready;

	// one line of the directed table: a register write or a sample word
	typedef struct packed {
		logic        is_cfg;
		logic [2:0]  reg_idx;
		logic [31:0] value;
		in_word_t    word;
		logic        known;
		out_word_t   known_result;
	} stim_row_t;

	cfg_t        cal_shadow = '0;
	out_word_t   pending_readings[$];
	stim_row_t   directed_rows[$];
	int          err_count   = 0;
	int unsigned cycle_count = 0;

	pressure_sensor_compensation_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.sample (sample),
		.done   (done),
		.result (result),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready)
	);

	// 12 ns clock
	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("pressure_sensor_compensation_unit test failed");
			$finish;
		end
	end

	// second-order compensation on the shadow calibration
	function automatic out_word_t compensate(input in_word_t w);
		longint press_raw, temp_raw;
		longint k_sens, k_off, k_sens_tc, k_off_tc, k_tref, k_tsens;
		longint delta_t, sensitivity, offset, temp_c, dev, dev_sq;
		longint corr_temp, corr_off, corr_sens, cold, press;
		out_word_t r;
		press_raw = w.raw_pressure;
		temp_raw  = w.raw_temperature;
		k_sens    = cal_shadow.sens_coeff;
		k_off     = cal_shadow.offset_coeff;
		k_sens_tc = cal_shadow.sens_temp_coeff;
		k_off_tc  = cal_shadow.offset_temp_coeff;
		k_tref    = cal_shadow.ref_temp_coeff;
		k_tsens   = cal_shadow.temp_sens_coeff;
		corr_temp = 0;
		corr_off  = 0;
		corr_sens = 0;

		// first order
		delta_t = temp_raw - k_tref * 256;
		if (cal_shadow.model_select) begin
			sensitivity = k_sens * 65536 + (k_sens_tc * delta_t) / 128;
			offset      = k_off * 131072 + (k_off_tc * delta_t) / 64;
		end else begin
			sensitivity = k_sens * 32768 + (k_sens_tc * delta_t) / 256;
			offset      = k_off * 65536 + (k_off_tc * delta_t) / 128;
		end
		temp_c = 2000 + (delta_t * k_tsens) / 64'sd8388608;
		dev    = temp_c - 2000;
		dev_sq = dev * dev;

		// second order by model and temperature band
		if (cal_shadow.model_select) begin
			if (temp_c / 100 < 20) begin
				corr_temp = (11 * delta_t * delta_t) / 64'sd34359738368;
				corr_off  = (31 * dev_sq) / 8;
				corr_sens = (63 * dev_sq) / 32;
			end
		end else begin
			if (temp_c / 100 < 20) begin
				corr_temp = (3 * delta_t * delta_t) / 64'sd8589934592;
				corr_off  = (3 * dev_sq) / 2;
				corr_sens = (5 * dev_sq) / 8;
				if (temp_c / 100 < -15) begin
					cold      = temp_c + 1500;
					corr_off  = corr_off + 7 * cold * cold;
					corr_sens = corr_sens + 4 * cold * cold;
				end
			end else begin
				corr_temp = (2 * delta_t * delta_t) / 64'sd137438953472;
				corr_off  = dev_sq / 16;
			end
		end
		offset      = offset - corr_off;
		sensitivity = sensitivity - corr_sens;
		temp_c      = temp_c - corr_temp;

		if (cal_shadow.model_select)
			press = ((press_raw * sensitivity) / 64'sd2097152 - offset) / 32768;
		else
			press = ((press_raw * sensitivity) / 64'sd2097152 - offset) / 8192;
		r.temperature_centi = temp_c[31:0];
		r.pressure_value    = press[31:0];
		return r;
	endfunction

	// result checker
	always @(posedge clk) begin
		out_word_t want;
		if (arst_n && done) begin
			if (pending_readings.size() == 0) begin
				err_count++;
				$display("%0t: result word with none expected: temperature %0d pressure %0d",
					$time, result.temperature_centi, result.pressure_value);
			end else begin
				want = pending_readings.pop_front();
				if (result.temperature_centi !== want.temperature_centi) begin
					err_count++;
					$display("%0t: temperature_centi expected %0d got %0d",
						$time, want.temperature_centi, result.temperature_centi);
				end
				if (result.pressure_value !== want.pressure_value) begin
					err_count++;
					$display("%0t: pressure_value expected %0d got %0d",
						$time, want.pressure_value, result.pressure_value);
				end
			end
		end
	end

	// offer one word; returns at the edge that takes it, start left high
	task automatic send_word(input in_word_t w, input out_word_t want);
		start  <= 1'b1;
		sample <= w;
		do @(posedge clk); while (busy);
		pending_readings.push_back(want);
	endtask

	task automatic wait_drained();
		while (pending_readings.size() != 0)
			@(posedge clk);
	endtask

	// apb write: setup, access, then idle with psel low
	task automatic reg_write(input logic [2:0] idx, input logic [31:0] val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		case (idx)
			REG_MODEL:     cal_shadow.model_select      = val[0];
			REG_SENS:      cal_shadow.sens_coeff        = val[15:0];
			REG_OFFSET:    cal_shadow.offset_coeff      = val[15:0];
			REG_SENS_TEMP: cal_shadow.sens_temp_coeff   = val[15:0];
			REG_OFF_TEMP:  cal_shadow.offset_temp_coeff = val[15:0];
			REG_REF_TEMP:  cal_shadow.ref_temp_coeff    = val[15:0];
			REG_TEMP_SENS: cal_shadow.temp_sens_coeff   = val[15:0];
			default:       ;
		endcase
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	function automatic stim_row_t cfg_row(input logic [2:0] idx, input logic [31:0] val);
		stim_row_t r;
		r         = '0;
		r.is_cfg  = 1'b1;
		r.reg_idx = idx;
		r.value   = val;
		return r;
	endfunction

	function automatic stim_row_t word_row(input logic [23:0] p, input logic [23:0] t);
		stim_row_t r;
		r                      = '0;
		r.word.raw_pressure    = p;
		r.word.raw_temperature = t;
		return r;
	endfunction

	function automatic stim_row_t known_row(input logic [23:0] p, input logic [23:0] t,
		input logic signed [31:0] temp_exp, input logic signed [31:0] press_exp);
		stim_row_t r;
		r                                = word_row(p, t);
		r.known                          = 1'b1;
		r.known_result.temperature_centi = temp_exp;
		r.known_result.pressure_value    = press_exp;
		return r;
	endfunction

	// temperature codes that land on the band edges with ref = tsens = 32768
	localparam logic [23:0] T_AT_REF   = 24'd8388608;
	localparam logic [23:0] T_JUST_LOW = 24'd8388308;
	localparam logic [23:0] T_COLD_EDGE = 24'd7467264;
	localparam logic [23:0] T_VERY_COLD = 24'd7467008;

	initial begin
		stim_row_t row;
		in_word_t  w;
		int        burst_left, gap;
		int unsigned k, pick;
		longint    near_ref;
		logic [31:0] val;
		logic      drain_now;

		// all calibration zero after reset: outputs follow from the raw temperature only
		directed_rows.push_back(known_row(24'd0, 24'd0, 32'sd2000, 32'sd0));
		directed_rows.push_back(known_row(RAW_MAX, RAW_MAX, -32'sd2095, 32'sd0));
		directed_rows.push_back(known_row(RAW_MAX, 24'd0, 32'sd2000, 32'sd0));
		// every word at its maximum, 30 bar scaling; upper bits of the write are dropped
		directed_rows.push_back(cfg_row(REG_MODEL, 32'hFFFF_FFFE));
		directed_rows.push_back(cfg_row(REG_SENS, 32'hFFFF_FFFF));
		directed_rows.push_back(cfg_row(REG_OFFSET, 32'h0000_FFFF));
		directed_rows.push_back(cfg_row(REG_SENS_TEMP, 32'h0000_FFFF));
		directed_rows.push_back(cfg_row(REG_OFF_TEMP, 32'h0000_FFFF));
		directed_rows.push_back(cfg_row(REG_REF_TEMP, 32'h0000_FFFF));
		directed_rows.push_back(cfg_row(REG_TEMP_SENS, 32'h0000_FFFF));
		directed_rows.push_back(word_row(RAW_MAX, 24'd0));
		directed_rows.push_back(word_row(24'd0, RAW_MAX));
		directed_rows.push_back(word_row(RAW_MAX, RAW_MAX));
		directed_rows.push_back(word_row(24'h800000, 24'h800000));
		// mid-scale part placed so that temperature lands on band edges
		directed_rows.push_back(cfg_row(REG_SENS, 32'd46372));
		directed_rows.push_back(cfg_row(REG_OFFSET, 32'd43981));
		directed_rows.push_back(cfg_row(REG_SENS_TEMP, 32'd29059));
		directed_rows.push_back(cfg_row(REG_OFF_TEMP, 32'd27842));
		directed_rows.push_back(cfg_row(REG_REF_TEMP, 32'd32768));
		directed_rows.push_back(cfg_row(REG_TEMP_SENS, 32'd32768));
		// unmapped register: must leave everything as it is
		directed_rows.push_back(cfg_row(REG_UNMAPPED, 32'hFFFF_FFFF));
		directed_rows.push_back(word_row(24'h4A0000, T_AT_REF));
		directed_rows.push_back(word_row(24'h4A0000, T_JUST_LOW));
		directed_rows.push_back(word_row(24'h4A0000, T_COLD_EDGE));
		directed_rows.push_back(word_row(24'h4A0000, T_VERY_COLD));
		directed_rows.push_back(word_row(RAW_MAX, 24'd0));
		directed_rows.push_back(word_row(RAW_MAX, RAW_MAX));
		// most of the same points with 2 bar scaling, including no correction when warm
		directed_rows.push_back(cfg_row(REG_MODEL, 32'h0000_0003));
		directed_rows.push_back(word_row(24'h4A0000, T_AT_REF));
		directed_rows.push_back(word_row(24'h4A0000, T_JUST_LOW));
		directed_rows.push_back(word_row(24'h4A0000, T_VERY_COLD));
		directed_rows.push_back(word_row(RAW_MAX, 24'd0));
		directed_rows.push_back(word_row(RAW_MAX, RAW_MAX));
		// 2 bar scaling, every word at its maximum
		directed_rows.push_back(cfg_row(REG_SENS, 32'h0000_FFFF));
		directed_rows.push_back(cfg_row(REG_OFFSET, 32'h0000_FFFF));
		directed_rows.push_back(cfg_row(REG_SENS_TEMP, 32'h0000_FFFF));
		directed_rows.push_back(cfg_row(REG_OFF_TEMP, 32'h0000_FFFF));
		directed_rows.push_back(cfg_row(REG_REF_TEMP, 32'h0000_FFFF));
		directed_rows.push_back(cfg_row(REG_TEMP_SENS, 32'h0000_FFFF));
		directed_rows.push_back(word_row(RAW_MAX, RAW_MAX));
		directed_rows.push_back(word_row(RAW_MAX, 24'd0));
		directed_rows.push_back(word_row(24'd0, 24'd0));

		// reset
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed table
		foreach (directed_rows[i]) begin
			row = directed_rows[i];
			if (row.is_cfg) begin
				start <= 1'b0;
				wait_drained();
				reg_write(row.reg_idx, row.value);
			end else begin
				send_word(row.word, row.known ? row.known_result : compensate(row.word));
			end
		end
		start <= 1'b0;

		// random phases: new calibration, then bursts of words
		for (int ph = 0; ph < PHASES; ph++) begin
			wait_drained();
			reg_write(REG_MODEL, ($urandom & 32'hFFFF_FFFE) | $urandom_range(0, 1));
			for (int r = REG_SENS; r <= REG_TEMP_SENS; r++) begin
				pick = $urandom_range(0, 5);
				val  = (pick == 0) ? 32'd0 : (pick == 1) ? 32'h0000_FFFF : {16'd0, 16'($urandom)};
				if ($urandom_range(0, 3) == 0)
					val[31:16] = 16'($urandom);
				reg_write(3'(r), val);
			end
			if ($urandom_range(0, 2) == 0)
				reg_write(REG_UNMAPPED, $urandom);

			burst_left = $urandom_range(1, 30);
			for (int n = 0; n < PHASE_WORDS; n++) begin
				w.raw_pressure = 24'($urandom);
				// half the temperatures near the reference so the bands are crossed
				if ($urandom_range(0, 1) == 0) begin
					k        = $urandom_range(0, 23);
					near_ref = longint'(cal_shadow.ref_temp_coeff) * 256
						+ longint'($urandom_range(0, 2 << k)) - longint'(1 << k);
					if (near_ref < 0)
						near_ref = 0;
					if (near_ref > longint'(RAW_MAX))
						near_ref = longint'(RAW_MAX);
					w.raw_temperature = near_ref[23:0];
				end else begin
					w.raw_temperature = 24'($urandom);
				end
				send_word(w, compensate(w));

				// burst bookkeeping, plus one full drain mid-run
				gap = 0;
				burst_left--;
				if (burst_left == 0) begin
					gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
					burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200)
						: $urandom_range(1, 30);
				end
				drain_now = (ph == 5 && n == PHASE_WORDS / 2);
				if (gap > 0 || drain_now)
					start <= 1'b0;
				repeat (gap) @(posedge clk);
				if (drain_now)
					wait_drained();
			end
			start <= 1'b0;
			@(posedge clk);
		end

		// let the pipeline empty, then watch for stray words
		wait_drained();
		repeat (20) @(posedge clk);
		if (err_count == 0)
			$display("pressure_sensor_compensation_unit test passed");
		else
			$display("pressure_sensor_compensation_unit test failed");
		$finish;
	end

endmodule

@@ files.f @@
rtl/pscu_pkg.sv
rtl/pscu_front.sv
rtl/pscu_corr.sv
rtl/pscu_pres.sv
rtl/pressure_sensor_compensation_unit.sv
rtl/pscu_checker.sv
test/tb_top.sv
